// ===== hw/rtl/ims_pkg.sv =====
package ims_pkg;

  // transaction opcodes
  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_STATUS  = 2'd1,
    OP_TIMEOUT = 2'd2
  } op_e;

  // commands to the bus controller
  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_SI      = 3'd1,
    CMD_STA_SI  = 3'd2,
    CMD_STO_SI  = 3'd3,
    CMD_STA_STO = 3'd4,
    CMD_STA     = 3'd5,
    CMD_CLR_TO  = 3'd6
  } cmd_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_SLAVE_ADDR = 3'd0,
    CFG_TX_LEN     = 3'd1,
    CFG_READ_MODE  = 3'd2,
    CFG_TX_BYTE0   = 3'd3,
    CFG_TX_BYTE1   = 3'd4,
    CFG_TX_BYTE2   = 3'd5
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  // controller status codes
  localparam logic [7:0] ST_START    = 8'h08;
  localparam logic [7:0] ST_RSTART   = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK = 8'h18;
  localparam logic [7:0] ST_SLAW_NAK = 8'h20;
  localparam logic [7:0] ST_DATA_ACK = 8'h28;
  localparam logic [7:0] ST_SLAR_ACK = 8'h40;
  localparam logic [7:0] ST_DATA_NAK = 8'h58;
  localparam logic [7:0] RD_BIT      = 8'h01;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] status;
    logic [7:0] bus_byte;
  } in_item_t;

  typedef struct packed {
    logic       load_data;
    logic [7:0] data_byte;
    cmd_e       command;
    logic       done_res;
    logic [7:0] rx_data;
    logic       unhandled;
  } out_item_t;

  typedef struct packed {
    logic [6:0] slave_addr;
    logic [1:0] tx_len;
    logic       read_mode;
    logic [7:0] tx_byte0;
    logic [7:0] tx_byte1;
    logic [7:0] tx_byte2;
  } cfg_t;

  typedef struct packed {
    logic [1:0] byte_index;
    logic       finished;
    logic [7:0] read_hold;
  } seq_state_t;

endpackage

// ===== hw/rtl/i2c_master_status_sequencer.sv =====
// a transaction accepted into the input register is decoded into the result register
// throughput: one transaction per cycle while the output is not stalled, set by the
// single decode pass between the input register and the result register
// reset (rst_ni low, asynchronous): byte index, done flag and captured byte
// clear, tx_len returns to one, other configuration registers to zero, both stages empty
module i2c_master_status_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ims_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ims_pkg::out_item_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [ims_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ims_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  ims_pkg::cfg_t       cfg;
  ims_pkg::seq_state_t state_q, state_d;
  ims_pkg::in_item_t   in_q;
  ims_pkg::out_item_t  out_q, out_d;
  logic                in_valid_q;
  logic                out_valid_q;
  logic                advance;

  // configuration registers
  ims_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // status decode: one pass from the held transaction and the current state
  ims_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (in_q),
    .state_o  (state_d),
    .result_o (out_d)
  );

  // the held transaction moves on when the result register is free or drains
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // sequencer state follows each transaction as it leaves the decode pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a result without a load carries a zero byte
  a_no_load_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.load_data |-> out_data_o.data_byte == 8'd0)
    else $error("data byte set without load");

  // an unknown status never issues a command
  a_unh_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.unhandled |-> out_data_o.command == ims_pkg::CMD_NONE)
    else $error("unhandled status with command");

  // a start transaction clears the done flag and byte index
  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.op == ims_pkg::OP_START |=> !state_q.finished && state_q.byte_index == 2'd0)
    else $error("start did not clear sequencer state");

  // input stalls only while a transaction is held
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_q)
    else $error("input stalled with free stage");

  // the done flag of a delivered result matches the sequencer state
  a_done_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_data_o.done_res == state_q.finished)
    else $error("done flag out of step with state");

endmodule

// ===== hw/rtl/ims_cfg.sv =====
module ims_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ims_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ims_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output ims_pkg::cfg_t                 cfg_o
);

  ims_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ims_pkg::CFG_SLAVE_ADDR: cfg_d.slave_addr = cfg_wdata_i[6:0];
        ims_pkg::CFG_TX_LEN:     cfg_d.tx_len     = cfg_wdata_i[1:0];
        ims_pkg::CFG_READ_MODE:  cfg_d.read_mode  = cfg_wdata_i[0];
        ims_pkg::CFG_TX_BYTE0:   cfg_d.tx_byte0   = cfg_wdata_i;
        ims_pkg::CFG_TX_BYTE1:   cfg_d.tx_byte1   = cfg_wdata_i;
        ims_pkg::CFG_TX_BYTE2:   cfg_d.tx_byte2   = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slave_addr <= 7'd0;
      cfg_q.tx_len     <= 2'd1;
      cfg_q.read_mode  <= 1'b0;
      cfg_q.tx_byte0   <= 8'd0;
      cfg_q.tx_byte1   <= 8'd0;
      cfg_q.tx_byte2   <= 8'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/ims_step.sv =====
module ims_step (
  input  ims_pkg::cfg_t       cfg_i,
  input  ims_pkg::seq_state_t state_i,
  input  ims_pkg::in_item_t   item_i,
  output ims_pkg::seq_state_t state_o,
  output ims_pkg::out_item_t  result_o
);

  logic [7:0] addr_w;
  logic [7:0] payload;
  logic       load;
  logic [7:0] dbyte;
  logic       unh;
  ims_pkg::cmd_e cmd;

  assign addr_w = {cfg_i.slave_addr, 1'b0};

  // payload slot three does not exist and sends zero
  always_comb begin
    unique case (state_i.byte_index)
      2'd0:    payload = cfg_i.tx_byte0;
      2'd1:    payload = cfg_i.tx_byte1;
      2'd2:    payload = cfg_i.tx_byte2;
      default: payload = 8'd0;
    endcase
  end

  always_comb begin
    state_o = state_i;
    load    = 1'b0;
    dbyte   = 8'd0;
    cmd     = ims_pkg::CMD_NONE;
    unh     = 1'b0;
    unique case (item_i.op)
      ims_pkg::OP_START: begin
        state_o.byte_index = 2'd0;
        state_o.finished   = 1'b0;
        cmd                = ims_pkg::CMD_STA;
      end
      ims_pkg::OP_TIMEOUT: cmd = ims_pkg::CMD_CLR_TO;
      ims_pkg::OP_STATUS: begin
        priority if (item_i.status == ims_pkg::ST_START) begin
          load  = 1'b1;
          dbyte = addr_w;
          cmd   = ims_pkg::CMD_SI;
        end else if (item_i.status == ims_pkg::ST_SLAW_ACK) begin
          load               = 1'b1;
          dbyte              = payload;
          cmd                = ims_pkg::CMD_SI;
          state_o.byte_index = state_i.byte_index + 2'd1;
        end else if (item_i.status == ims_pkg::ST_SLAW_NAK) begin
          cmd = ims_pkg::CMD_STA_STO;
        end else if (item_i.status == ims_pkg::ST_DATA_ACK) begin
          priority if (state_i.byte_index != cfg_i.tx_len) begin
            load               = 1'b1;
            dbyte              = payload;
            cmd                = ims_pkg::CMD_SI;
            state_o.byte_index = state_i.byte_index + 2'd1;
          end else if (cfg_i.read_mode) begin
            cmd = ims_pkg::CMD_STA_SI;
          end else begin
            cmd              = ims_pkg::CMD_STO_SI;
            state_o.finished = 1'b1;
          end
        end else if (cfg_i.read_mode && item_i.status == ims_pkg::ST_RSTART) begin
          load  = 1'b1;
          dbyte = addr_w | ims_pkg::RD_BIT;
          cmd   = ims_pkg::CMD_SI;
        end else if (cfg_i.read_mode && item_i.status == ims_pkg::ST_SLAR_ACK) begin
          cmd = ims_pkg::CMD_SI;
        end else if (cfg_i.read_mode && item_i.status == ims_pkg::ST_DATA_NAK) begin
          state_o.read_hold = item_i.bus_byte;
          state_o.finished  = 1'b1;
          cmd               = ims_pkg::CMD_STO_SI;
        end else begin
          unh = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign result_o.load_data = load;
  assign result_o.data_byte = dbyte;
  assign result_o.command   = cmd;
  assign result_o.done_res  = state_o.finished;
  assign result_o.rx_data   = state_o.read_hold;
  assign result_o.unhandled = unh;

endmodule

// ===== dv/i2c_master_status_sequencer_tb.sv =====
module i2c_master_status_sequencer_tb;
  import ims_pkg::*;

  // generous ceiling on the whole run, in clock cycles
  localparam int unsigned CycleLimit = 200000;
  // index past the register list, written once to show it is ignored
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 3'd7;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #4 clk_i = ~clk_i;

  // block inputs, all known from time zero
  logic                in_valid_q  = 1'b0;
  in_item_t            in_data_q   = '0;
  logic                out_ready_q = 1'b0;
  logic                cfg_we_q    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_q   = '0;
  logic [CfgDataW-1:0] cfg_wdata_q = '0;

  // block outputs
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_data_o;

  i2c_master_status_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_q),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_q),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_q),
    .cfg_idx_i   (cfg_idx_q),
    .cfg_wdata_i (cfg_wdata_q)
  );

  // shadow copies of the configuration and the sequencer state
  cfg_t       cfg_shadow;
  seq_state_t seq_shadow;

  // transactions waiting to be driven, and responses still owed by the block
  in_item_t  stim_q[$];
  out_item_t expected_resp_q[$];

  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  int unsigned src_gap     = 0;
  int unsigned sink_stall  = 0;
  // no idling on either side while set
  bit          quiet_mode  = 1'b0;

  // payload slot lookup, slot three does not exist and reads as zero
  function automatic logic [7:0] payload_byte(logic [1:0] idx);
    case (idx)
      2'd0:    return cfg_shadow.tx_byte0;
      2'd1:    return cfg_shadow.tx_byte1;
      2'd2:    return cfg_shadow.tx_byte2;
      default: return 8'h00;
    endcase
  endfunction

  // works out the response to one accepted transaction and advances the shadow state
  function automatic out_item_t predict_response(in_item_t it);
    out_item_t  r;
    logic [7:0] addr_w;
    r         = '0;
    r.command = CMD_NONE;
    addr_w    = {cfg_shadow.slave_addr, 1'b0};
    case (it.op)
      OP_START: begin
        seq_shadow.byte_index = 2'd0;
        seq_shadow.finished   = 1'b0;
        r.command             = CMD_STA;
      end
      OP_TIMEOUT: begin
        r.command = CMD_CLR_TO;
      end
      OP_STATUS: begin
        if (it.status == ST_START) begin
          r.load_data = 1'b1;
          r.data_byte = addr_w;
          r.command   = CMD_SI;
        end else if (it.status == ST_SLAW_ACK) begin
          r.load_data           = 1'b1;
          r.data_byte           = payload_byte(seq_shadow.byte_index);
          r.command             = CMD_SI;
          seq_shadow.byte_index = seq_shadow.byte_index + 2'd1;
        end else if (it.status == ST_SLAW_NAK) begin
          // address refused: start and stop, nothing else moves
          r.command = CMD_STA_STO;
        end else if (it.status == ST_DATA_ACK) begin
          if (seq_shadow.byte_index != cfg_shadow.tx_len) begin
            r.load_data           = 1'b1;
            r.data_byte           = payload_byte(seq_shadow.byte_index);
            r.command             = CMD_SI;
            seq_shadow.byte_index = seq_shadow.byte_index + 2'd1;
          end else if (cfg_shadow.read_mode) begin
            r.command = CMD_STA_SI;
          end else begin
            r.command           = CMD_STO_SI;
            seq_shadow.finished = 1'b1;
          end
        end else if (cfg_shadow.read_mode && it.status == ST_RSTART) begin
          r.load_data = 1'b1;
          r.data_byte = addr_w | RD_BIT;
          r.command   = CMD_SI;
        end else if (cfg_shadow.read_mode && it.status == ST_SLAR_ACK) begin
          r.command = CMD_SI;
        end else if (cfg_shadow.read_mode && it.status == ST_DATA_NAK) begin
          seq_shadow.read_hold = it.bus_byte;
          r.command            = CMD_STO_SI;
          seq_shadow.finished  = 1'b1;
        end else begin
          r.unhandled = 1'b1;
        end
      end
      default: ;  // op three does nothing at all
    endcase
    r.done_res = seq_shadow.finished;
    r.rx_data  = seq_shadow.read_hold;
    return r;
  endfunction

  // driver: feeds the input channel from the stimulus queue, with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_q && in_ready_o) begin
        expected_resp_q.push_back(predict_response(in_data_q));
      end
      // only move on once the current transaction has gone, valid must hold
      if (!in_valid_q || in_ready_o) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid_q <= 1'b0;
        end else if (stim_q.size() == 0) begin
          in_valid_q <= 1'b0;
        end else if (!quiet_mode && $urandom_range(0, 4) == 0) begin
          // idle burst
          src_gap = $urandom_range(0, 11);
          in_valid_q <= 1'b0;
        end else begin
          in_data_q  <= stim_q.pop_front();
          in_valid_q <= 1'b1;
        end
      end
    end
  end

  // monitor: takes responses with random back-pressure and checks each field
  always @(posedge clk_i) begin
    out_item_t exp_resp;
    if (rst_ni) begin
      if (out_valid_o && out_ready_q) begin
        if (expected_resp_q.size() == 0) begin
          $error("response with nothing expected: %h", out_data_o);
          err_count++;
        end else begin
          exp_resp = expected_resp_q.pop_front();
          if (out_data_o.load_data !== exp_resp.load_data) begin
            $error("load_data: expected %0h, got %0h", exp_resp.load_data,
                   out_data_o.load_data);
            err_count++;
          end
          if (out_data_o.data_byte !== exp_resp.data_byte) begin
            $error("data_byte: expected %0h, got %0h", exp_resp.data_byte,
                   out_data_o.data_byte);
            err_count++;
          end
          if (out_data_o.command !== exp_resp.command) begin
            $error("command: expected %0h, got %0h", exp_resp.command,
                   out_data_o.command);
            err_count++;
          end
          if (out_data_o.done_res !== exp_resp.done_res) begin
            $error("done_res: expected %0h, got %0h", exp_resp.done_res,
                   out_data_o.done_res);
            err_count++;
          end
          if (out_data_o.rx_data !== exp_resp.rx_data) begin
            $error("rx_data: expected %0h, got %0h", exp_resp.rx_data,
                   out_data_o.rx_data);
            err_count++;
          end
          if (out_data_o.unhandled !== exp_resp.unhandled) begin
            $error("unhandled: expected %0h, got %0h", exp_resp.unhandled,
                   out_data_o.unhandled);
            err_count++;
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        out_ready_q <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
        // stall burst
        sink_stall = $urandom_range(0, 11);
        out_ready_q <= 1'b0;
      end else begin
        out_ready_q <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL i2c_master_status_sequencer");
      $finish;
    end
  end

  task automatic push_item(logic [1:0] op, logic [7:0] st, logic [7:0] bb);
    in_item_t it;
    it.op       = op;
    it.status   = st;
    it.bus_byte = bb;
    stim_q.push_back(it);
  endtask

  // one register write, the shadow follows the same masking as the block
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_q    <= 1'b1;
    cfg_idx_q   <= idx;
    cfg_wdata_q <= val;
    case (idx)
      CFG_SLAVE_ADDR: cfg_shadow.slave_addr = val[6:0];
      CFG_TX_LEN:     cfg_shadow.tx_len     = val[1:0];
      CFG_READ_MODE:  cfg_shadow.read_mode  = val[0];
      CFG_TX_BYTE0:   cfg_shadow.tx_byte0   = val;
      CFG_TX_BYTE1:   cfg_shadow.tx_byte1   = val;
      CFG_TX_BYTE2:   cfg_shadow.tx_byte2   = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_q <= 1'b0;
  endtask

  // block is idle once nothing is queued, in flight or owed, plus a margin
  task automatic wait_idle();
    while (stim_q.size() != 0 || in_valid_q || expected_resp_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  // status code for a noise transaction, biased towards the decoded ones
  function automatic logic [7:0] noise_status();
    case ($urandom_range(0, 9))
      0: return ST_START;
      1: return ST_RSTART;
      2: return ST_SLAW_ACK;
      3: return ST_SLAW_NAK;
      4: return ST_DATA_ACK;
      5: return ST_SLAR_ACK;
      6: return ST_DATA_NAK;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // random settings, then mostly well-formed bus transactions with some noise
  task automatic run_random_phase(int unsigned n_items, bit no_idle);
    int unsigned made;
    int unsigned n_data;
    logic [7:0]  v;
    case ($urandom_range(0, 3))
      0:       v = 8'h00;
      1:       v = 8'h7f;
      default: v = 8'($urandom_range(0, 255));
    endcase
    write_reg(CFG_SLAVE_ADDR, v);
    write_reg(CFG_TX_LEN, 8'($urandom_range(0, 255)));
    write_reg(CFG_READ_MODE, 8'($urandom_range(0, 255)));
    write_reg(CFG_TX_BYTE0, 8'($urandom_range(0, 255)));
    write_reg(CFG_TX_BYTE1, 8'($urandom_range(0, 255)));
    write_reg(CFG_TX_BYTE2, 8'($urandom_range(0, 255)));
    @(negedge clk_i);
    quiet_mode = no_idle;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 4) != 0) begin
        push_item(OP_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        push_item(OP_STATUS, ST_START, 8'($urandom_range(0, 255)));
        made += 2;
        if ($urandom_range(0, 7) == 0) begin
          push_item(OP_STATUS, ST_SLAW_NAK, 8'($urandom_range(0, 255)));
          made++;
        end else begin
          push_item(OP_STATUS, ST_SLAW_ACK, 8'($urandom_range(0, 255)));
          // enough acks to reach the configured length, index wraps for zero
          n_data = ((cfg_shadow.tx_len - 2'd1) & 2'd3) + 1;
          repeat (n_data) begin
            if ($urandom_range(0, 11) == 0) begin
              push_item(OP_TIMEOUT, 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
              made++;
            end
            push_item(OP_STATUS, ST_DATA_ACK, 8'($urandom_range(0, 255)));
          end
          made += n_data + 1;
          if (cfg_shadow.read_mode) begin
            push_item(OP_STATUS, ST_RSTART, 8'($urandom_range(0, 255)));
            push_item(OP_STATUS, ST_SLAR_ACK, 8'($urandom_range(0, 255)));
            push_item(OP_STATUS, ST_DATA_NAK, 8'($urandom_range(0, 255)));
            made += 3;
          end
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          push_item(2'($urandom_range(0, 3)), noise_status(), 8'($urandom_range(0, 255)));
          made++;
        end
      end
    end
    wait_idle();
  endtask

  initial begin
    cfg_shadow        = '0;
    cfg_shadow.tx_len = 2'd1;
    seq_shadow        = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: address zero, one byte, write mode
    push_item(2'd3, 8'hff, 8'hff);                    // unused op is a no-op
    push_item(OP_START, 8'h00, 8'h00);
    push_item(OP_STATUS, ST_START, 8'h00);
    push_item(OP_STATUS, ST_SLAW_ACK, 8'hff);
    push_item(OP_STATUS, ST_DATA_ACK, 8'h00);
    push_item(OP_STATUS, ST_DATA_ACK, 8'h00);         // stop and done
    push_item(OP_STATUS, ST_SLAW_NAK, 8'h00);         // address nack
    push_item(OP_TIMEOUT, 8'hff, 8'h00);
    push_item(OP_STATUS, 8'h00, 8'h00);               // unknown codes
    push_item(OP_STATUS, 8'hff, 8'hff);
    push_item(OP_STATUS, ST_DATA_NAK, 8'h5a);         // read-only codes in write mode
    push_item(OP_STATUS, ST_RSTART, 8'h00);
    push_item(OP_STATUS, ST_SLAR_ACK, 8'h00);
    wait_idle();

    // widest address, longest payload, read mode
    write_reg(CFG_SLAVE_ADDR, 8'hff);
    write_reg(CFG_TX_LEN, 8'h03);
    write_reg(CFG_READ_MODE, 8'h01);
    write_reg(CFG_TX_BYTE0, 8'hff);
    write_reg(CFG_TX_BYTE1, 8'h00);
    write_reg(CFG_TX_BYTE2, 8'ha5);
    write_reg(CfgIdxUnused, 8'hff);
    @(negedge clk_i);
    push_item(OP_START, 8'hff, 8'hff);
    push_item(OP_STATUS, ST_START, 8'h00);
    push_item(OP_STATUS, ST_SLAW_ACK, 8'h00);
    push_item(OP_STATUS, ST_DATA_ACK, 8'h00);
    push_item(OP_STATUS, ST_DATA_ACK, 8'h00);
    push_item(OP_STATUS, ST_DATA_ACK, 8'h00);         // index three, repeated start
    push_item(OP_STATUS, ST_RSTART, 8'h00);
    push_item(OP_STATUS, ST_SLAR_ACK, 8'h00);
    push_item(OP_STATUS, ST_DATA_NAK, 8'hff);         // capture
    push_item(OP_STATUS, ST_SLAW_ACK, 8'h00);         // slot three sends zero, index wraps
    push_item(OP_STATUS, ST_DATA_NAK, 8'h00);
    wait_idle();

    // random settings, a calm phase in the middle and another at the end
    repeat (3) run_random_phase(85, 1'b0);
    run_random_phase(85, 1'b1);
    repeat (3) run_random_phase(85, 1'b0);
    run_random_phase(85, 1'b1);

    repeat (8) @(negedge clk_i);
    if (expected_resp_q.size() != 0) begin
      $error("responses never arrived: %0d", expected_resp_q.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("PASS i2c_master_status_sequencer");
    end else begin
      $display("FAIL i2c_master_status_sequencer");
    end
    $finish;
  end

endmodule
